// ===== rtl/core/qpm_pkg.sv =====
// Shared types, constants and corner-index helpers for the quad projective map.
// No dependencies; every other file in rtl/core imports this package.
package qpm_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int UV_W            = 18;
    localparam int CW_W            = 20;
    localparam int KIND_W          = 4;
    localparam int CFG_IDX_W       = 4;
    localparam int JOB_DEPTH       = 4;
    localparam int JAC_FRAC        = 16;
    localparam int NUM_CORNERS     = 4;
    localparam int NUM_REGS        = 8;

    // barycentric weight of the first triangle is one minus u minus v
    localparam logic [CW_W-1:0] CW_ONE = CW_W'(65536);

    typedef struct packed {
        logic [UV_W-1:0] u;
        logic [UV_W-1:0] v;
        logic [CW_W-1:0] cw;
        logic            mode;
    } t_job;

    typedef struct packed {
        logic       hit;
        logic [1:0] q;
        logic [1:0] r;
    } t_dpos;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AREA,
        ST_ALPHA,
        ST_NUM,
        ST_CHECK,
        ST_PDIV,
        ST_PEMIT,
        ST_DEN,
        ST_AH,
        ST_REL,
        ST_COLINIT,
        ST_DA,
        ST_DAR,
        ST_JDIV,
        ST_JEMIT,
        ST_DEGEMIT
    } t_bstate;

    function automatic logic [1:0] f_next3(input logic [1:0] p);
        return (p == 2'd2) ? 2'd0 : p + 2'd1;
    endfunction

    // corner at position p of triangle t: {1,2,3}, {0,2,3}, {0,1,2}
    function automatic logic [1:0] f_tri_pt(input logic [1:0] t, input logic [1:0] p);
        logic [1:0] r;
        if (t == 2'd2) begin
            r = p;
        end else if (t == 2'd1 && p == 2'd0) begin
            r = 2'd0;
        end else begin
            r = p + 2'd1;
        end
        return r;
    endfunction

    // corner whose weight triangle t carries
    function automatic logic [1:0] f_owner(input logic [1:0] t);
        return (t == 2'd2) ? 2'd3 : t;
    endfunction

    // triangle that carries corner c directly (c is 0, 1 or 3)
    function automatic logic [1:0] f_col_tri(input logic [1:0] c);
        return (c == 2'd3) ? 2'd2 : c;
    endfunction

    // neighbors of corner c inside triangle t, for the area derivative
    function automatic t_dpos f_dpos(input logic [1:0] t, input logic [1:0] c);
        t_dpos d;
        d = '0;
        for (int p = 0; p < 3; p++) begin
            if (f_tri_pt(t, 2'(p)) == c) begin
                d.hit = 1'b1;
                d.q   = f_tri_pt(t, f_next3(2'(p)));
                d.r   = f_tri_pt(t, f_next3(f_next3(2'(p))));
            end
        end
        return d;
    endfunction

endpackage

// ===== rtl/core/qpm_front.sv =====
// Front end: corner registers, input word intake and the job queue to the back end.
// Depends on qpm_pkg.
module qpm_front import qpm_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [COORD_WIDTH-1:0] i_cfg_data,
    output logic                   o_cfg_ready,
    input  logic                   i_push,
    input  logic [UV_W-1:0]        i_u,
    input  logic [UV_W-1:0]        i_v,
    input  logic                   i_mode,
    output logic                   o_full,
    output logic                   o_job_valid,
    output t_job                   o_job,
    input  logic                   i_job_take,
    output logic [COORD_WIDTH-1:0] o_cx [NUM_CORNERS],
    output logic [COORD_WIDTH-1:0] o_cy [NUM_CORNERS]
);

    localparam int PTR_W = $clog2(JOB_DEPTH);
    localparam int CNT_W = $clog2(JOB_DEPTH + 1);

    logic [COORD_WIDTH-1:0] r_cx [NUM_CORNERS];
    logic [COORD_WIDTH-1:0] r_cy [NUM_CORNERS];
    t_job                   r_mem [JOB_DEPTH];
    logic [PTR_W-1:0]       r_wr, r_rd;
    logic [CNT_W-1:0]       r_cnt;
    logic                   push_ok;
    t_job                   new_job;

    assign o_cfg_ready = 1'b1;
    assign o_full      = (r_cnt == CNT_W'(JOB_DEPTH));
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_mem[r_rd];
    assign o_cx        = r_cx;
    assign o_cy        = r_cy;
    assign push_ok     = i_push && !o_full;

    always_comb begin
        new_job.u    = i_u;
        new_job.v    = i_v;
        new_job.cw   = CW_ONE - {{(CW_W-UV_W){i_u[UV_W-1]}}, i_u}
                              - {{(CW_W-UV_W){i_v[UV_W-1]}}, i_v};
        new_job.mode = i_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CORNERS; i++) begin
                r_cx[i] <= '0;
                r_cy[i] <= '0;
            end
        end else if (i_cfg_valid && i_cfg_index < CFG_IDX_W'(NUM_REGS)) begin
            // odd index is y, even is x; ignore anything past the last corner
            if (i_cfg_index[0]) begin
                r_cy[i_cfg_index[2:1]] <= i_cfg_data;
            end else begin
                r_cx[i_cfg_index[2:1]] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= new_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_job_take) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(push_ok) - CNT_W'(i_job_take);
        end
    end

endmodule

// ===== rtl/core/qpm_mul.sv =====
// Shift-add multiplier, one bit of the second operand per cycle, two's complement.
// Depends on qpm_pkg for the default coordinate width.
module qpm_mul import qpm_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int PW          = 4 * COORD_WIDTH + 72,
    parameter int NW          = $clog2(PW + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [PW-1:0] i_a,
    input  logic [PW-1:0] i_b,
    input  logic [NW-1:0] i_n,
    output logic          o_done,
    output logic [PW-1:0] o_p
);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [NW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] r_a, n_a;
    logic [PW-1:0] r_b, n_b;
    logic [PW-1:0] r_p, n_p;

    assign o_done = r_done;
    assign o_p    = r_p;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_p    = r_p;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = i_n;
            n_a    = i_a;
            n_b    = i_b;
            n_p    = '0;
        end else if (r_busy) begin
            // top bit of the n-bit operand carries negative weight
            if (r_b[0]) begin
                n_p = (r_cnt == NW'(1)) ? r_p - r_a : r_p + r_a;
            end
            n_a   = {r_a[PW-2:0], 1'b0};
            n_b   = {1'b0, r_b[PW-1:1]};
            n_cnt = r_cnt - NW'(1);
            if (r_cnt == NW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_a   <= n_a;
        r_b   <= n_b;
        r_p   <= n_p;
    end

endmodule

// ===== rtl/core/qpm_div.sv =====
// Restoring divider: round(num/den) to nearest, ties away from zero, saturated.
// Depends on qpm_pkg for the default coordinate width; one quotient bit per cycle.
module qpm_div import qpm_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int PW          = 4 * COORD_WIDTH + 72
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [PW-1:0]          i_num,
    input  logic [PW-1:0]          i_den,
    output logic                   o_done,
    output logic [COORD_WIDTH-1:0] o_q
);

    localparam int W   = COORD_WIDTH;
    localparam int QW  = W + 1;
    localparam int RW  = PW + 2;
    localparam int SW  = RW + W;
    localparam int CNT = $clog2(QW + 1);

    logic [PW-1:0]  an, ad;
    logic [RW-1:0]  num2, den2;
    logic           big;
    logic [SW-1:0]  rem_x;
    logic           ge;

    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [CNT-1:0] r_cnt, n_cnt;
    logic [RW-1:0]  r_rem, n_rem;
    logic [SW-1:0]  r_dsh, n_dsh;
    logic [QW-1:0]  r_q, n_q;
    logic           r_neg, n_neg;
    logic           r_big, n_big;

    assign an    = i_num[PW-1] ? -i_num : i_num;
    assign ad    = i_den[PW-1] ? -i_den : i_den;
    assign num2  = {1'b0, an, 1'b0} + {2'b00, ad};
    assign den2  = {1'b0, ad, 1'b0};
    assign big   = (num2 >> (W + 1)) >= den2;
    assign rem_x = {{W{1'b0}}, r_rem};
    assign ge    = rem_x >= r_dsh;
    assign o_done = r_done;

    always_comb begin
        if (!r_neg) begin
            if (r_big || r_q > {2'b00, {(W-1){1'b1}}}) begin
                o_q = {1'b0, {(W-1){1'b1}}};
            end else begin
                o_q = r_q[W-1:0];
            end
        end else begin
            if (r_big || r_q > {2'b01, {(W-1){1'b0}}}) begin
                o_q = {1'b1, {(W-1){1'b0}}};
            end else begin
                o_q = W'(-r_q);
            end
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_q    = r_q;
        n_neg  = r_neg;
        n_big  = r_big;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT'(QW);
            n_rem  = num2;
            n_dsh  = {{W{1'b0}}, den2} << W;
            n_q    = '0;
            n_neg  = i_num[PW-1] ^ i_den[PW-1];
            n_big  = big;
        end else if (r_busy) begin
            if (ge) begin
                n_rem = r_rem - r_dsh[RW-1:0];
            end
            n_q   = {r_q[QW-2:0], ge};
            n_dsh = r_dsh >> 1;
            n_cnt = r_cnt - CNT'(1);
            if (r_cnt == CNT'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_q   <= n_q;
        r_neg <= n_neg;
        r_big <= n_big;
    end

endmodule

// ===== rtl/core/qpm_back.sv =====
// Back end: sequencer over one shared multiplier and divider, plus the result register.
// Depends on qpm_pkg, qpm_mul and qpm_div.
module qpm_back import qpm_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_job_valid,
    input  t_job                   i_job,
    output logic                   o_job_take,
    input  logic [COORD_WIDTH-1:0] i_cx [NUM_CORNERS],
    input  logic [COORD_WIDTH-1:0] i_cy [NUM_CORNERS],
    input  logic                   i_pop,
    output logic                   o_empty,
    output logic [KIND_W-1:0]      o_item_kind,
    output logic [COORD_WIDTH-1:0] o_first_value,
    output logic [COORD_WIDTH-1:0] o_second_value,
    output logic                   o_degenerate,
    output logic                   o_last
);

    localparam int W       = COORD_WIDTH;
    localparam int PW      = 4 * W + 72;
    localparam int NW      = $clog2(PW + 1);
    localparam int ALPHA_W = 2 * W + 23;
    localparam int HW_W    = 2 * W + 25;
    localparam int DA_W    = W + CW_W + 1;

    function automatic logic [PW-1:0] f_sxc(input logic [W-1:0] x);
        return {{(PW-W){x[W-1]}}, x};
    endfunction

    function automatic logic [PW-1:0] f_sxd(input logic [W:0] x);
        return {{(PW-W-1){x[W]}}, x};
    endfunction

    function automatic logic [PW-1:0] f_sxw(input logic [CW_W-1:0] x);
        return {{(PW-CW_W){x[CW_W-1]}}, x};
    endfunction

    function automatic logic [W:0] f_diff(input logic [W-1:0] a, input logic [W-1:0] b);
        return {a[W-1], a} - {b[W-1], b};
    endfunction

    t_bstate          r_state, n_state;
    logic             r_issued, n_issued;
    logic [CW_W-1:0]  r_cw [3];
    logic [CW_W-1:0]  n_cw [3];
    logic             r_mode, n_mode;
    logic [PW-1:0]    r_area [3];
    logic [PW-1:0]    n_area [3];
    logic [PW-1:0]    r_alpha [3];
    logic [PW-1:0]    n_alpha [3];
    logic [PW-1:0]    r_ah [3];
    logic [PW-1:0]    n_ah [3];
    logic [PW-1:0]    r_rel [3][2];
    logic [PW-1:0]    n_rel [3][2];
    logic [PW-1:0]    r_num [2];
    logic [PW-1:0]    n_num [2];
    logic [PW-1:0]    r_hw, n_hw;
    logic [PW-1:0]    r_den, n_den;
    logic [PW-1:0]    r_acc, n_acc;
    logic [PW-1:0]    r_tmp, n_tmp;
    logic [W-1:0]     r_q [2];
    logic [W-1:0]     n_q [2];
    logic [1:0]       r_t, n_t;
    logic [1:0]       r_k, n_k;
    logic             r_b, n_b;
    logic [KIND_W-1:0] r_j, n_j;

    logic                r_ov, n_ov;
    logic [KIND_W-1:0]   r_okind, n_okind;
    logic [W-1:0]        r_ofirst, n_ofirst;
    logic [W-1:0]        r_osecond, n_osecond;
    logic                r_odeg, n_odeg;
    logic                r_olast, n_olast;

    logic          mul_start, mul_done;
    logic [PW-1:0] mul_a, mul_b, mul_p;
    logic [NW-1:0] mul_n;
    logic          div_start, div_done;
    logic [PW-1:0] div_n, div_d;
    logic [W-1:0]  div_q;

    logic          out_free;
    logic [1:0]    p1, p2, ci, cj, ck, col, own;
    logic          axis;
    t_dpos         dp;
    logic [W:0]    dv;

    assign out_free       = !r_ov || i_pop;
    assign o_empty        = !r_ov;
    assign o_item_kind    = r_okind;
    assign o_first_value  = r_ofirst;
    assign o_second_value = r_osecond;
    assign o_degenerate   = r_odeg;
    assign o_last         = r_olast;

    assign p1   = f_next3(r_k);
    assign p2   = f_next3(p1);
    assign ci   = f_tri_pt(r_t, r_k);
    assign cj   = f_tri_pt(r_t, p1);
    assign ck   = f_tri_pt(r_t, p2);
    assign own  = f_owner(r_t);
    assign col  = r_j[2:1];
    assign axis = r_j[0];
    assign dp   = f_dpos(r_t, col);
    assign dv   = axis ? f_diff(i_cx[dp.r], i_cx[dp.q]) : f_diff(i_cy[dp.q], i_cy[dp.r]);

    qpm_mul #(.COORD_WIDTH(COORD_WIDTH), .PW(PW), .NW(NW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_n     (mul_n),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    qpm_div #(.COORD_WIDTH(COORD_WIDTH), .PW(PW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_n),
        .i_den   (div_d),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    always_comb begin
        n_state   = r_state;
        n_issued  = r_issued;
        n_cw      = r_cw;
        n_mode    = r_mode;
        n_area    = r_area;
        n_alpha   = r_alpha;
        n_ah      = r_ah;
        n_rel     = r_rel;
        n_num     = r_num;
        n_hw      = r_hw;
        n_den     = r_den;
        n_acc     = r_acc;
        n_tmp     = r_tmp;
        n_q       = r_q;
        n_t       = r_t;
        n_k       = r_k;
        n_b       = r_b;
        n_j       = r_j;
        n_ov      = r_ov && !i_pop;
        n_okind   = r_okind;
        n_ofirst  = r_ofirst;
        n_osecond = r_osecond;
        n_odeg    = r_odeg;
        n_olast   = r_olast;
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        mul_n     = '0;
        div_start = 1'b0;
        div_n     = '0;
        div_d     = '0;
        o_job_take = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_take = 1'b1;
                    n_cw[0]  = i_job.cw;
                    n_cw[1]  = {{(CW_W-UV_W){i_job.u[UV_W-1]}}, i_job.u};
                    n_cw[2]  = {{(CW_W-UV_W){i_job.v[UV_W-1]}}, i_job.v};
                    n_mode   = i_job.mode;
                    n_t      = '0;
                    n_k      = '0;
                    n_b      = 1'b0;
                    n_acc    = '0;
                    n_issued = 1'b0;
                    n_state  = ST_AREA;
                end
            end
            ST_AREA: begin
                mul_start = !r_issued;
                n_issued  = 1'b1;
                mul_a     = f_sxc(i_cx[ci]);
                mul_b     = f_sxd(f_diff(i_cy[cj], i_cy[ck]));
                mul_n     = NW'(W + 1);
                if (mul_done) begin
                    n_issued = 1'b0;
                    if (r_k == 2'd2) begin
                        n_area[r_t] = r_acc + mul_p;
                        n_acc = '0;
                        n_k   = '0;
                        if (r_t == 2'd2) begin
                            n_t     = '0;
                            n_state = ST_ALPHA;
                        end else begin
                            n_t = r_t + 2'd1;
                        end
                    end else begin
                        n_acc = r_acc + mul_p;
                        n_k   = r_k + 2'd1;
                    end
                end
            end
            ST_ALPHA: begin
                mul_start = !r_issued;
                n_issued  = 1'b1;
                mul_a     = r_area[r_t];
                mul_b     = f_sxw(r_cw[r_t]);
                mul_n     = NW'(CW_W);
                if (mul_done) begin
                    n_issued     = 1'b0;
                    n_alpha[r_t] = mul_p;
                    n_hw         = (r_t == 2'd0) ? mul_p : r_hw + mul_p;
                    if (r_t == 2'd2) begin
                        n_t     = '0;
                        n_b     = 1'b0;
                        n_acc   = '0;
                        n_state = ST_NUM;
                    end else begin
                        n_t = r_t + 2'd1;
                    end
                end
            end
            ST_NUM: begin
                mul_start = !r_issued;
                n_issued  = 1'b1;
                mul_a     = r_alpha[r_t];
                mul_b     = f_sxc(r_b ? i_cy[own] : i_cx[own]);
                mul_n     = NW'(W);
                if (mul_done) begin
                    n_issued = 1'b0;
                    if (r_t == 2'd2) begin
                        n_num[r_b] = r_acc + mul_p;
                        n_acc = '0;
                        n_t   = '0;
                        n_b   = !r_b;
                        if (r_b) begin
                            n_state = ST_CHECK;
                        end
                    end else begin
                        n_acc = r_acc + mul_p;
                        n_t   = r_t + 2'd1;
                    end
                end
            end
            ST_CHECK: begin
                n_b = 1'b0;
                n_j = '0;
                if (r_area[0] == '0 || r_hw == '0) begin
                    n_state = ST_DEGEMIT;
                end else begin
                    n_state = ST_PDIV;
                end
            end
            ST_PDIV: begin
                div_start = !r_issued;
                n_issued  = 1'b1;
                div_n     = r_num[r_b];
                div_d     = r_hw;
                if (div_done) begin
                    n_issued = 1'b0;
                    n_q[r_b] = div_q;
                    n_b      = !r_b;
                    if (r_b) begin
                        n_state = ST_PEMIT;
                    end
                end
            end
            ST_PEMIT: begin
                if (out_free) begin
                    n_ov      = 1'b1;
                    n_okind   = '0;
                    n_ofirst  = r_q[0];
                    n_osecond = r_q[1];
                    n_odeg    = 1'b0;
                    n_olast   = !r_mode;
                    n_state   = r_mode ? ST_DEN : ST_IDLE;
                end
            end
            ST_DEN: begin
                mul_start = !r_issued;
                n_issued  = 1'b1;
                mul_a     = r_hw;
                mul_b     = r_hw;
                mul_n     = NW'(HW_W);
                if (mul_done) begin
                    n_issued = 1'b0;
                    n_den    = mul_p;
                    n_t      = '0;
                    n_state  = ST_AH;
                end
            end
            ST_AH: begin
                mul_start = !r_issued;
                n_issued  = 1'b1;
                mul_a     = r_hw;
                mul_b     = r_alpha[r_t];
                mul_n     = NW'(ALPHA_W);
                if (mul_done) begin
                    n_issued  = 1'b0;
                    n_ah[r_t] = mul_p;
                    if (r_t == 2'd2) begin
                        n_t     = '0;
                        n_b     = 1'b0;
                        n_state = ST_REL;
                    end else begin
                        n_t = r_t + 2'd1;
                    end
                end
            end
            ST_REL: begin
                // coordinate times hw, less the numerator of that axis
                mul_start = !r_issued;
                n_issued  = 1'b1;
                mul_a     = r_hw;
                mul_b     = f_sxc(r_b ? i_cy[own] : i_cx[own]);
                mul_n     = NW'(W);
                if (mul_done) begin
                    n_issued         = 1'b0;
                    n_rel[r_t][r_b]  = mul_p - r_num[r_b];
                    n_b              = !r_b;
                    if (r_b) begin
                        if (r_t == 2'd2) begin
                            n_t     = '0;
                            n_j     = '0;
                            n_state = ST_COLINIT;
                        end else begin
                            n_t = r_t + 2'd1;
                        end
                    end
                end
            end
            ST_COLINIT: begin
                n_acc   = (col != 2'd2 && axis == r_b) ? r_ah[f_col_tri(col)] : '0;
                n_t     = '0;
                n_state = ST_DA;
            end
            ST_DA: begin
                if (!dp.hit) begin
                    // corner not in this triangle: no term
                    if (r_t == 2'd2) begin
                        n_state = ST_JDIV;
                    end else begin
                        n_t = r_t + 2'd1;
                    end
                end else begin
                    mul_start = !r_issued;
                    n_issued  = 1'b1;
                    mul_a     = f_sxd(dv);
                    mul_b     = f_sxw(r_cw[r_t]);
                    mul_n     = NW'(CW_W);
                    if (mul_done) begin
                        n_issued = 1'b0;
                        n_tmp    = mul_p;
                        n_state  = ST_DAR;
                    end
                end
            end
            ST_DAR: begin
                mul_start = !r_issued;
                n_issued  = 1'b1;
                mul_a     = r_rel[r_t][r_b];
                mul_b     = r_tmp;
                mul_n     = NW'(DA_W);
                if (mul_done) begin
                    n_issued = 1'b0;
                    n_acc    = r_acc + mul_p;
                    if (r_t == 2'd2) begin
                        n_state = ST_JDIV;
                    end else begin
                        n_t     = r_t + 2'd1;
                        n_state = ST_DA;
                    end
                end
            end
            ST_JDIV: begin
                div_start = !r_issued;
                n_issued  = 1'b1;
                div_n     = {r_acc[PW-JAC_FRAC-1:0], {JAC_FRAC{1'b0}}};
                div_d     = r_den;
                if (div_done) begin
                    n_issued = 1'b0;
                    n_q[r_b] = div_q;
                    n_b      = !r_b;
                    n_state  = r_b ? ST_JEMIT : ST_COLINIT;
                end
            end
            ST_JEMIT: begin
                if (out_free) begin
                    n_ov      = 1'b1;
                    n_okind   = r_j + KIND_W'(1);
                    n_ofirst  = r_q[0];
                    n_osecond = r_q[1];
                    n_odeg    = 1'b0;
                    n_olast   = (r_j == KIND_W'(7));
                    if (r_j == KIND_W'(7)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_j     = r_j + KIND_W'(1);
                        n_state = ST_COLINIT;
                    end
                end
            end
            ST_DEGEMIT: begin
                if (out_free) begin
                    n_ov      = 1'b1;
                    n_okind   = r_j;
                    n_ofirst  = '0;
                    n_osecond = '0;
                    n_odeg    = 1'b1;
                    n_olast   = !r_mode || r_j == KIND_W'(8);
                    if (!r_mode || r_j == KIND_W'(8)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_j = r_j + KIND_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_issued <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cw      <= n_cw;
        r_mode    <= n_mode;
        r_area    <= n_area;
        r_alpha   <= n_alpha;
        r_ah      <= n_ah;
        r_rel     <= n_rel;
        r_num     <= n_num;
        r_hw      <= n_hw;
        r_den     <= n_den;
        r_acc     <= n_acc;
        r_tmp     <= n_tmp;
        r_q       <= n_q;
        r_t       <= n_t;
        r_k       <= n_k;
        r_b       <= n_b;
        r_j       <= n_j;
        r_okind   <= n_okind;
        r_ofirst  <= n_ofirst;
        r_osecond <= n_osecond;
        r_odeg    <= n_odeg;
        r_olast   <= n_olast;
    end

endmodule

// ===== rtl/core/quad_projective_map.sv =====
// Top level of the quad projective map: front end with job queue, back end sequencer.
// Depends on qpm_pkg, qpm_front and qpm_back.
//
//   channel   handshake                 word
//   input     push / full               u, v, mode
//   result    empty / pop               item_kind, first_value, second_value, degenerate, last
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data (corner register)
//
// Each word runs through one shared shift-add multiplier (one operand bit per cycle)
// and one restoring divider (one quotient bit per cycle).
// Up to four words wait in the job queue; the result register holds while pop is low.
// Reset clears the corners to zero and empties queue and result register.
module quad_projective_map import qpm_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [COORD_WIDTH-1:0] i_cfg_data,
    output logic                   o_cfg_ready,
    input  logic                   push,
    output logic                   full,
    input  logic [UV_W-1:0]        i_u,
    input  logic [UV_W-1:0]        i_v,
    input  logic                   i_mode,
    output logic                   empty,
    input  logic                   pop,
    output logic [KIND_W-1:0]      o_item_kind,
    output logic [COORD_WIDTH-1:0] o_first_value,
    output logic [COORD_WIDTH-1:0] o_second_value,
    output logic                   o_degenerate,
    output logic                   o_last
);

    logic                   job_valid;
    logic                   job_take;
    t_job                   job;
    logic [COORD_WIDTH-1:0] cx [NUM_CORNERS];
    logic [COORD_WIDTH-1:0] cy [NUM_CORNERS];

    qpm_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_push      (push),
        .i_u         (i_u),
        .i_v         (i_v),
        .i_mode      (i_mode),
        .o_full      (full),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_take  (job_take),
        .o_cx        (cx),
        .o_cy        (cy)
    );

    qpm_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (job_valid),
        .i_job          (job),
        .o_job_take     (job_take),
        .i_cx           (cx),
        .i_cy           (cy),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_item_kind    (o_item_kind),
        .o_first_value  (o_first_value),
        .o_second_value (o_second_value),
        .o_degenerate   (o_degenerate),
        .o_last         (o_last)
    );

endmodule
